[hw/rtl/kpr_pkg.sv]
// Shared types and constants of the Kermit packet receiver.
package kpr_pkg;

	localparam int PADDR_W = 5;

	localparam logic [7:0] MARK_BYTE  = 8'h01;
	localparam logic [7:0] CHAR_BIAS  = 8'd32;
	localparam logic [7:0] CTRL_FLIP  = 8'h40;
	localparam logic [7:0] HIGH_FLIP  = 8'h80;
	localparam logic [7:0] LOW7_MASK  = 8'h7f;
	localparam logic [1:0] CHK_TWELVE = 2'd2;

	localparam logic [2:0] REG_CHECK_TYPE  = 3'd0;
	localparam logic [2:0] REG_CTRL_QUOTE  = 3'd1;
	localparam logic [2:0] REG_BIN_QUOTE   = 3'd2;
	localparam logic [2:0] REG_REPEAT_CHAR = 3'd3;
	localparam logic [2:0] REG_BIN_ON      = 3'd4;
	localparam logic [2:0] REG_REPEAT_ON   = 3'd5;

	localparam logic RESULT_DATA    = 1'b0;
	localparam logic RESULT_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		PH_MARK = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] check_type;
		logic [7:0] control_quote_char;
		logic [7:0] binary_quote_char;
		logic [7:0] repeat_prefix_char;
		logic       binary_quote_on;
		logic       repeat_on;
	} cfg_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_value;
		logic [7:0] repeat_times;
		logic [7:0] sequence_value;
		logic [7:0] packet_kind_char;
		logic       check_passed;
	} res_t;

endpackage

[hw/rtl/kpr_cfg_regs.sv]
// Configuration registers of the Kermit packet receiver behind an APB-style port.
module kpr_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kpr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output kpr_pkg::cfg_t              cfg
);

	kpr_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_type         <= 2'd1;
			cfg_q.control_quote_char <= 8'd35;
			cfg_q.binary_quote_char  <= 8'd89;
			cfg_q.repeat_prefix_char <= 8'd126;
			cfg_q.binary_quote_on    <= 1'b0;
			cfg_q.repeat_on          <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				kpr_pkg::REG_CHECK_TYPE:  cfg_q.check_type         <= pwdata[1:0];
				kpr_pkg::REG_CTRL_QUOTE:  cfg_q.control_quote_char <= pwdata[7:0];
				kpr_pkg::REG_BIN_QUOTE:   cfg_q.binary_quote_char  <= pwdata[7:0];
				kpr_pkg::REG_REPEAT_CHAR: cfg_q.repeat_prefix_char <= pwdata[7:0];
				kpr_pkg::REG_BIN_ON:      cfg_q.binary_quote_on    <= pwdata[0];
				kpr_pkg::REG_REPEAT_ON:   cfg_q.repeat_on          <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			kpr_pkg::REG_CHECK_TYPE:  prdata = {30'd0, cfg_q.check_type};
			kpr_pkg::REG_CTRL_QUOTE:  prdata = {24'd0, cfg_q.control_quote_char};
			kpr_pkg::REG_BIN_QUOTE:   prdata = {24'd0, cfg_q.binary_quote_char};
			kpr_pkg::REG_REPEAT_CHAR: prdata = {24'd0, cfg_q.repeat_prefix_char};
			kpr_pkg::REG_BIN_ON:      prdata = {31'd0, cfg_q.binary_quote_on};
			kpr_pkg::REG_REPEAT_ON:   prdata = {31'd0, cfg_q.repeat_on};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

[hw/rtl/kpr_decode.sv]
// Packet framing, running sum, prefix decoding and verdicts: one line byte per cycle on fire.
module kpr_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  kpr_pkg::cfg_t cfg,
	input  logic          fire,
	input  logic [7:0]    line_byte,
	output logic          res_valid,
	output kpr_pkg::res_t res
);

	kpr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  rem_q, rem_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  typ_q, typ_d;
	logic [7:0]  fc_q, fc_d;
	logic        cp_q, cp_d;
	logic        bp_q, bp_d;
	logic        rp_q, rp_d;
	logic [7:0]  rh_q, rh_d;

	logic       chk2;
	logic [1:0] chk;
	logic [8:0] pos_chk;
	logic       in_data;
	logic [7:0] low7;
	logic [7:0] dec_val;
	logic       emit;
	logic       pass;
	logic [7:0] c0_12;
	logic [7:0] c1_12;
	logic [5:0] fold6;
	logic [7:0] c0_6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kpr_pkg::PH_MARK;
			rem_q   <= 8'd0;
			pos_q   <= 8'd0;
			len_q   <= 8'd0;
			sum_q   <= 16'd0;
			seq_q   <= 8'd0;
			typ_q   <= 8'd0;
			fc_q    <= 8'd0;
			cp_q    <= 1'b0;
			bp_q    <= 1'b0;
			rp_q    <= 1'b0;
			rh_q    <= 8'd1;
		end else if (fire) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			seq_q   <= seq_d;
			typ_q   <= typ_d;
			fc_q    <= fc_d;
			cp_q    <= cp_d;
			bp_q    <= bp_d;
			rp_q    <= rp_d;
			rh_q    <= rh_d;
		end
	end

	assign chk2    = (cfg.check_type == kpr_pkg::CHK_TWELVE);
	assign chk     = chk2 ? 2'd2 : 2'd1;
	assign pos_chk = {1'b0, pos_q} + {7'd0, chk};
	assign in_data = (pos_chk < {1'b0, len_q});
	assign low7    = line_byte & kpr_pkg::LOW7_MASK;

	// The sum never changes on the last byte, so the check uses the stored sum.
	assign c0_12 = {2'b00, sum_q[11:6]} + kpr_pkg::CHAR_BIAS;
	assign c1_12 = {2'b00, sum_q[5:0]} + kpr_pkg::CHAR_BIAS;
	assign fold6 = sum_q[5:0] + {4'd0, sum_q[7:6]};
	assign c0_6  = {2'b00, fold6} + kpr_pkg::CHAR_BIAS;

	always_comb begin
		if ({1'b0, len_q} < ({7'd0, chk} + 9'd2)) begin
			pass = 1'b0;
		end else if (chk2) begin
			pass = (fc_q == c0_12) && (line_byte == c1_12);
		end else begin
			pass = (line_byte == c0_6);
		end
	end

	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		pos_d     = pos_q;
		len_d     = len_q;
		sum_d     = sum_q;
		seq_d     = seq_q;
		typ_d     = typ_q;
		fc_d      = fc_q;
		cp_d      = cp_q;
		bp_d      = bp_q;
		rp_d      = rp_q;
		rh_d      = rh_q;
		dec_val   = line_byte;
		emit      = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (line_byte == kpr_pkg::MARK_BYTE) begin
			phase_d = kpr_pkg::PH_LEN;
		end else begin
			case (phase_q)
				kpr_pkg::PH_LEN: begin
					len_d = line_byte - kpr_pkg::CHAR_BIAS;
					rem_d = line_byte - kpr_pkg::CHAR_BIAS;
					pos_d = 8'd0;
					sum_d = {8'd0, line_byte};
					seq_d = 8'd0;
					typ_d = 8'd0;
					fc_d  = 8'd0;
					cp_d  = 1'b0;
					bp_d  = 1'b0;
					rp_d  = 1'b0;
					rh_d  = 8'd1;
					if (line_byte == kpr_pkg::CHAR_BIAS) begin
						phase_d = kpr_pkg::PH_MARK;
						res_valid = 1'b1;
						res.result_kind = kpr_pkg::RESULT_VERDICT;
					end else begin
						phase_d = kpr_pkg::PH_BODY;
					end
				end
				kpr_pkg::PH_BODY: begin
					if (in_data) begin
						sum_d = sum_q + {8'd0, line_byte};
					end
					if (pos_q == 8'd0) begin
						seq_d = line_byte - kpr_pkg::CHAR_BIAS;
					end else if (pos_q == 8'd1) begin
						typ_d = line_byte;
					end else if (in_data) begin
						if (cp_q) begin
							if (low7 != cfg.control_quote_char &&
								!(cfg.binary_quote_on && low7 == cfg.binary_quote_char) &&
								!(cfg.repeat_on && low7 == cfg.repeat_prefix_char)) begin
								dec_val = line_byte ^ kpr_pkg::CTRL_FLIP;
							end
							emit = 1'b1;
						end else if (cfg.repeat_on && rp_q) begin
							rh_d = line_byte - kpr_pkg::CHAR_BIAS;
							rp_d = 1'b0;
						end else if (line_byte == cfg.control_quote_char) begin
							cp_d = 1'b1;
						end else if (cfg.binary_quote_on &&
							line_byte == cfg.binary_quote_char) begin
							bp_d = 1'b1;
						end else if (cfg.repeat_on && line_byte == cfg.repeat_prefix_char) begin
							rp_d = 1'b1;
						end else begin
							emit = 1'b1;
						end
						if (emit) begin
							cp_d = 1'b0;
							bp_d = 1'b0;
							rp_d = 1'b0;
							rh_d = 8'd1;
							if (rh_q != 8'd0) begin
								res_valid = 1'b1;
								res.result_kind  = kpr_pkg::RESULT_DATA;
								res.data_value   = (cfg.binary_quote_on && bp_q) ?
									(dec_val ^ kpr_pkg::HIGH_FLIP) : dec_val;
								res.repeat_times = rh_q;
							end
						end
					end else if (chk2 && (pos_q + 8'd2 == len_q)) begin
						fc_d = line_byte;
					end
					pos_d = pos_q + 8'd1;
					rem_d = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						phase_d = kpr_pkg::PH_MARK;
						res_valid = 1'b1;
						res = '0;
						res.result_kind      = kpr_pkg::RESULT_VERDICT;
						res.sequence_value   = seq_d;
						res.packet_kind_char = typ_d;
						res.check_passed     = pass;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/kpr_out_fifo.sv]
// Two-entry result buffer that drives the master-side stream.
module kpr_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kpr_pkg::res_t push_res,
	output logic          full,
	output logic          m_tvalid,
	input  logic          m_tready,
	output kpr_pkg::res_t head_res
);

	kpr_pkg::res_t slot_q [2];
	logic          head_q;
	logic [1:0]    count_q;
	logic          pop;
	logic          wr_ptr;

	assign full     = (count_q == 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	assign wr_ptr   = head_q ^ count_q[0];
	assign head_res = slot_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (pop) begin
				head_q <= ~head_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word pushed into a full result buffer");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && count_q == 2'd0) |=> (count_q == 2'd1))
		else $error("result buffer lost a pushed word");

endmodule

[hw/rtl/kermit_packet_receiver.sv]
// Top level of the Kermit packet receiver: input register, decoder and result buffer.
//
// Line bytes enter on the slave stream (s_tdata[7:0]), one word per byte.
// MARK (0x01) starts a packet; LEN, SEQ, TYPE, data and one or two check
// characters follow. Each decoded data byte leaves on the master stream with
// m_tuser low, carrying the byte and its repeat count. The last byte of a
// packet yields a verdict word with m_tuser high, carrying SEQ, TYPE and the
// check result. Data words of a failed packet must be discarded by the user.
// A byte is registered on acceptance, decoded once the output buffer has room
// and its result is written into a two-entry output buffer that drives m_tvalid.
// One byte is accepted per cycle for as long as the output buffer is not full;
// s_tready is driven from registers only. When the receiver of the master
// stream stalls, the buffer fills and s_tready drops after at most two held
// words, with no word lost. Nothing in the block guards register writes: the
// user must write registers over the APB-style port only while no packet is
// active. Reset clears the framing state and loads the register defaults (one
// check character, quotes '#', 'Y', '~', eight-bit quoting and repeats off).
module kermit_packet_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] line_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata,   // [7:0] data_value, [15:8] repeat_times,
	                                               // [23:16] sequence_value,
	                                               // [31:24] packet_kind_char, [32] check_passed
	output logic [0:0]                  m_tuser,   // [0] result_kind
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kpr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	kpr_pkg::cfg_t cfg;
	kpr_pkg::res_t dec_res;
	kpr_pkg::res_t head_res;
	logic          dec_valid;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          fifo_full;
	logic          advance;

	assign advance  = valid_s1 & ~fifo_full;
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	kpr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kpr_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (advance),
		.line_byte (byte_s1),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	kpr_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance & dec_valid),
		.push_res (dec_res),
		.full     (fifo_full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head_res (head_res)
	);

	assign m_tuser = head_res.result_kind;
	assign m_tdata = {7'd0, head_res.check_passed, head_res.packet_kind_char,
		head_res.sequence_value, head_res.repeat_times, head_res.data_value};

endmodule

[verif/testbench.sv]
// Self-checking testbench for the Kermit packet receiver: framed line traffic against a decoder model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LINK_SETTINGS = 8;
	localparam int BYTES_PER_SETTING = 225;
	localparam int DRAIN_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [kpr_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	kermit_packet_receiver i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	kpr_pkg::cfg_t link;
	kpr_pkg::phase_t phase;
	logic [7:0] remaining;
	logic [7:0] position;
	logic [7:0] length;
	logic [15:0] sum;
	logic [7:0] seq_held;
	logic [7:0] type_held;
	logic [7:0] first_check;
	bit ctl_pend;
	bit bin_pend;
	bit rep_pend;
	logic [7:0] rep_count;

	kpr_pkg::res_t packet_results[$];
	logic [7:0] packet_data[$];
	int mismatches = 0;
	int sent_bytes = 0;
	int cycles = 0;
	bit gaps_on = 1'b1;
	int stall_left = 0;

	function automatic void clear_quoting();
		ctl_pend = 1'b0;
		bin_pend = 1'b0;
		rep_pend = 1'b0;
		rep_count = 8'd1;
	endfunction

	function automatic void reset_model();
		link.check_type = 2'd1;
		link.control_quote_char = 8'd35;
		link.binary_quote_char = 8'd89;
		link.repeat_prefix_char = 8'd126;
		link.binary_quote_on = 1'b0;
		link.repeat_on = 1'b0;
		phase = kpr_pkg::PH_MARK;
		remaining = 8'd0;
		position = 8'd0;
		length = 8'd0;
		sum = 16'd0;
		seq_held = 8'd0;
		type_held = 8'd0;
		first_check = 8'd0;
		clear_quoting();
	endfunction

	function automatic int check_count();
		return (link.check_type == kpr_pkg::CHK_TWELVE) ? 2 : 1;
	endfunction

	function automatic void check_chars(input logic [15:0] s, input int chk,
			output logic [7:0] c0, output logic [7:0] c1);
		logic [15:0] folded;
		folded = s + {14'd0, s[7:6]};
		if (chk == 2) begin
			c0 = {2'b00, s[11:6]} + kpr_pkg::CHAR_BIAS;
			c1 = {2'b00, s[5:0]} + kpr_pkg::CHAR_BIAS;
		end else begin
			c0 = {2'b00, folded[5:0]} + kpr_pkg::CHAR_BIAS;
			c1 = 8'd0;
		end
	endfunction

	function automatic bit unquote(input logic [7:0] raw, output logic [7:0] value,
			output logic [7:0] count);
		logic [7:0] b;
		logic [7:0] low7;
		bit bq;
		bit rq;
		bit ready;
		b = raw;
		low7 = raw & kpr_pkg::LOW7_MASK;
		bq = link.binary_quote_on;
		rq = link.repeat_on;
		ready = 1'b0;
		if (ctl_pend) begin
			if (low7 != link.control_quote_char && !(bq && low7 == link.binary_quote_char) &&
					!(rq && low7 == link.repeat_prefix_char))
				b = b ^ kpr_pkg::CTRL_FLIP;
			ctl_pend = 1'b0;
			ready = 1'b1;
		end else if (rq && rep_pend) begin
			rep_count = b - kpr_pkg::CHAR_BIAS;
			rep_pend = 1'b0;
		end else if (b == link.control_quote_char) begin
			ctl_pend = 1'b1;
		end else if (bq && b == link.binary_quote_char) begin
			bin_pend = 1'b1;
		end else if (rq && b == link.repeat_prefix_char) begin
			rep_pend = 1'b1;
		end else begin
			ready = 1'b1;
		end
		value = b;
		count = rep_count;
		if (!ready)
			return 1'b0;
		if (bq && bin_pend)
			value = b ^ kpr_pkg::HIGH_FLIP;
		clear_quoting();
		return count != 8'd0;
	endfunction

	function automatic void receive_char(input logic [7:0] b);
		int chk;
		int pos;
		int len;
		logic [7:0] v;
		logic [7:0] n;
		logic [7:0] c0;
		logic [7:0] c1;
		kpr_pkg::res_t r;
		chk = check_count();
		r = '0;
		if (b == kpr_pkg::MARK_BYTE) begin
			phase = kpr_pkg::PH_LEN;
			return;
		end
		if (phase == kpr_pkg::PH_LEN) begin
			length = b - kpr_pkg::CHAR_BIAS;
			remaining = length;
			position = 8'd0;
			sum = {8'd0, b};
			seq_held = 8'd0;
			type_held = 8'd0;
			first_check = 8'd0;
			clear_quoting();
			if (length == 8'd0) begin
				phase = kpr_pkg::PH_MARK;
				r.result_kind = kpr_pkg::RESULT_VERDICT;
				packet_results.push_back(r);
			end else begin
				phase = kpr_pkg::PH_BODY;
			end
			return;
		end
		if (phase != kpr_pkg::PH_BODY)
			return;
		pos = int'(position);
		len = int'(length);
		if (pos + chk < len)
			sum = sum + {8'd0, b};
		if (pos == 0) begin
			seq_held = b - kpr_pkg::CHAR_BIAS;
		end else if (pos == 1) begin
			type_held = b;
		end else if (pos + chk < len) begin
			if (unquote(b, v, n)) begin
				r.result_kind = kpr_pkg::RESULT_DATA;
				r.data_value = v;
				r.repeat_times = n;
				packet_results.push_back(r);
			end
		end else if (chk == 2 && pos + 2 == len) begin
			first_check = b;
		end
		position = position + 8'd1;
		remaining = remaining - 8'd1;
		if (remaining == 8'd0) begin
			phase = kpr_pkg::PH_MARK;
			check_chars(sum, chk, c0, c1);
			r = '0;
			r.result_kind = kpr_pkg::RESULT_VERDICT;
			r.sequence_value = seq_held;
			r.packet_kind_char = type_held;
			if (len >= chk + 2)
				r.check_passed = (chk == 2) ? (first_check == c0 && b == c1) : (b == c0);
			packet_results.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : word_check
		kpr_pkg::res_t got;
		kpr_pkg::res_t want;
		if (m_tvalid && m_tready) begin
			got.result_kind = m_tuser[0];
			got.data_value = m_tdata[7:0];
			got.repeat_times = m_tdata[15:8];
			got.sequence_value = m_tdata[23:16];
			got.packet_kind_char = m_tdata[31:24];
			got.check_passed = m_tdata[32];
			if (packet_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected word %h", $realtime, got);
				mismatches = mismatches + 1;
			end else begin
				want = packet_results.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("%0t: word mismatch, expected %h actual %h",
							$realtime, want, got);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes = sent_bytes + 1;
		receive_char(b);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (packet_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic close_frame();
		if (phase == kpr_pkg::PH_LEN)
			send_byte(kpr_pkg::CHAR_BIAS);
		while (phase == kpr_pkg::PH_BODY)
			send_byte(8'h40);
		settle();
	endtask

	task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			kpr_pkg::REG_CHECK_TYPE:  link.check_type = value[1:0];
			kpr_pkg::REG_CTRL_QUOTE:  link.control_quote_char = value[7:0];
			kpr_pkg::REG_BIN_QUOTE:   link.binary_quote_char = value[7:0];
			kpr_pkg::REG_REPEAT_CHAR: link.repeat_prefix_char = value[7:0];
			kpr_pkg::REG_BIN_ON:      link.binary_quote_on = value[0];
			kpr_pkg::REG_REPEAT_ON:   link.repeat_on = value[0];
			default: ;
		endcase
	endtask

	task automatic program_link(input logic [1:0] ct, input logic [7:0] cq, input logic [7:0] bq,
			input logic [7:0] rp, input logic bon, input logic ron);
		apb_write(kpr_pkg::REG_CHECK_TYPE, {30'd0, ct});
		apb_write(kpr_pkg::REG_CTRL_QUOTE, {24'd0, cq});
		apb_write(kpr_pkg::REG_BIN_QUOTE, {24'd0, bq});
		apb_write(kpr_pkg::REG_REPEAT_CHAR, {24'd0, rp});
		apb_write(kpr_pkg::REG_BIN_ON, {31'd0, bon});
		apb_write(kpr_pkg::REG_REPEAT_ON, {31'd0, ron});
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == kpr_pkg::MARK_BYTE) ? 8'h00 : c;
	endfunction

	function automatic logic [7:0] data_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: c = link.control_quote_char;
			2: c = link.binary_quote_char;
			3: c = link.repeat_prefix_char;
			4, 5: c = 8'($urandom_range(0, 255));
			default: c = 8'($urandom_range(32, 126));
		endcase
		return (c == kpr_pkg::MARK_BYTE) ? 8'h02 : c;
	endfunction

	// Damage 1 overwrites one byte of the packet, damage 2 cuts it short.
	task automatic send_packet(input int damage);
		logic [7:0] frame[$];
		logic [15:0] s;
		logic [7:0] c0;
		logic [7:0] c1;
		int chk;
		int cut;
		int idx;
		chk = check_count();
		frame.push_back(kpr_pkg::MARK_BYTE);
		frame.push_back(8'(packet_data.size() + 2 + chk) + kpr_pkg::CHAR_BIAS);
		frame.push_back(any_char());
		frame.push_back(any_char());
		foreach (packet_data[i])
			frame.push_back(packet_data[i]);
		s = 16'd0;
		for (int i = 1; i < frame.size(); i++)
			s = s + {8'd0, frame[i]};
		check_chars(s, chk, c0, c1);
		frame.push_back(c0);
		if (chk == 2)
			frame.push_back(c1);
		cut = frame.size();
		if (damage == 1) begin
			idx = $urandom_range(1, frame.size() - 1);
			frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
		end else if (damage == 2) begin
			cut = $urandom_range(1, frame.size() - 1);
		end
		for (int i = 0; i < cut; i++)
			send_byte(frame[i]);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 1) == 0)
			send_byte(kpr_pkg::MARK_BYTE);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_framing();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(kpr_pkg::MARK_BYTE);
		send_byte(kpr_pkg::CHAR_BIAS);
		send_byte(kpr_pkg::MARK_BYTE);
		send_byte(8'h21);
		send_byte(8'h30);
		send_byte(kpr_pkg::MARK_BYTE);
		send_byte(8'h25);
		send_byte(8'h41);
		send_byte(kpr_pkg::MARK_BYTE);
		packet_data = '{8'h41, 8'h23, 8'h4a, 8'h7e};
		send_packet(0);
		settle();
	endtask

	task automatic test_prefixes();
		close_frame();
		program_link(kpr_pkg::CHK_TWELVE, 8'd35, 8'd89, 8'd126, 1'b1, 1'b1);
		packet_data = '{8'h7e, 8'h24, 8'h59, 8'h23, 8'h41, 8'h7e, 8'h20, 8'h78, 8'h23, 8'h23};
		send_packet(0);
		settle();
	endtask

	task automatic test_random_links();
		logic [1:0] ct[LINK_SETTINGS] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1};
		logic [7:0] cq;
		logic [7:0] bq;
		logic [7:0] rp;
		int goal;
		int pick;
		for (int p = 0; p < LINK_SETTINGS; p++) begin
			close_frame();
			if (p == 1) begin
				cq = 8'h00;
				bq = 8'hff;
				rp = 8'h00;
			end else if (p == 2) begin
				cq = 8'hff;
				bq = 8'h00;
				rp = 8'h7f;
			end else if (p == 0 || p >= 6) begin
				cq = 8'd35;
				bq = 8'd89;
				rp = 8'd126;
			end else begin
				cq = 8'($urandom_range(0, 255));
				bq = 8'($urandom_range(0, 255));
				rp = 8'($urandom_range(0, 255));
			end
			program_link(ct[p], cq, bq, rp, p[0] | (p == 7), p[1] | (p == 7));
			gaps_on = (p < 6) && (p != 3);
			goal = sent_bytes + BYTES_PER_SETTING;
			while (sent_bytes < goal) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					send_noise();
				end else begin
					packet_data.delete();
					repeat (($urandom_range(0, 19) == 0) ? $urandom_range(0, 200)
							: $urandom_range(0, 12))
						packet_data.push_back(data_char());
					send_packet((pick <= 2) ? pick : 0);
				end
			end
			settle();
		end
	endtask

	initial begin
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_framing();
		test_prefixes();
		test_random_links();
		close_frame();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/kpr_pkg.sv
hw/rtl/kpr_cfg_regs.sv
hw/rtl/kpr_decode.sv
hw/rtl/kpr_out_fifo.sv
hw/rtl/kermit_packet_receiver.sv
verif/testbench.sv
